// File: rtl/ale_pkg.sv
// Shared types for the array list engine: command and status codes,
// controller-to-datapath command word and datapath status word.
// No dependencies.
`default_nettype none

package ale_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_GET    = 2'd2,
		CMD_SEARCH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    latch;
		logic    rd;
		logic    wr_shift;
		logic    wr_val;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    hit;
		logic    finish;
		status_t status;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic bad;
		logic full;
		logic empty;
		logic tail;
		logic rd_last;
		logic rdv;
		logic match;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/array_list_engine.sv
// Array list engine top level: ordered list in a store with one read and one
// write port, with insert, remove, get and search commands. Depends on
// ale_pkg, ale_ctrl, ale_dpath.
//
//  word      signals                                      handshake
//  command   command, use_last, position, value           taken when start && !busy
//  result    status, count, found, found_index,           done high for one cycle
//            read_value, is_full, is_empty
//
// Errors, append, get and tail remove need no walk. Insert and remove at a
// position shift every entry behind it, and search scans from the first entry
// until a match or the last entry. The walk moves one entry per cycle through
// the store's single read and single write port.
// Reset clears the count and the controller; store contents are undefined.
// Results are not held off by the receiver; busy stays high until done.
`default_nettype none

module array_list_engine #(
	parameter int CAPACITY   = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic        use_last,
	input  wire logic [7:0]  position,
	input  wire logic [31:0] value,
	output logic             done,
	output logic [1:0]       status,
	output logic [8:0]       count,
	output logic             found,
	output logic [7:0]       found_index,
	output logic [31:0]      read_value,
	output logic             is_full,
	output logic             is_empty
);

	ale_pkg::ctrl_t ctrl;
	ale_pkg::stat_t stat;

	ale_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	ale_dpath #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.command     (command),
		.use_last    (use_last),
		.position    (position),
		.value       (value),
		.status      (status),
		.count       (count),
		.found       (found),
		.found_index (found_index),
		.read_value  (read_value),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

endmodule

`default_nettype wire

// File: rtl/ale_dpath.sv
// Datapath of the array list engine: entry store, count, walk pointer,
// read pipeline and result registers.
// Depends on ale_pkg.
`default_nettype none

module ale_dpath #(
	parameter int CAPACITY   = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ale_pkg::ctrl_t    ctrl,
	output ale_pkg::stat_t         stat,
	input  wire logic [1:0]        command,
	input  wire logic              use_last,
	input  wire logic [7:0]        position,
	input  wire logic [31:0]       value,
	output logic [1:0]             status,
	output logic [8:0]             count,
	output logic                   found,
	output logic [7:0]             found_index,
	output logic [31:0]            read_value,
	output logic                   is_full,
	output logic                   is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = (CW > 8) ? CW : 8;

	logic [ELEM_WIDTH-1:0] store_q [CAPACITY];

	logic [CW-1:0]         count_q;
	ale_pkg::cmd_t         cmd_q;
	logic [AW-1:0]         tgt_q;
	logic                  bad_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [AW-1:0]         rd_ptr_q;
	logic                  rdv_s1;
	logic [AW-1:0]         rdaddr_s1;
	logic [ELEM_WIDTH-1:0] rdata_s1;

	logic [1:0]            status_q;
	logic [8:0]            count_res_q;
	logic                  found_q;
	logic [7:0]            found_index_q;
	logic [31:0]           read_value_q;
	logic                  is_full_q;
	logic                  is_empty_q;

	ale_pkg::cmd_t         cmd_in;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         cnt_w;
	logic                  pos_ok;
	logic                  cnt_zero;
	logic                  cnt_full;
	logic [AW-1:0]         last_idx;
	logic [AW-1:0]         pos_idx;
	logic [AW-1:0]         tgt_d;
	logic                  bad_d;
	logic [AW-1:0]         ptr_d;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;

	assign cmd_in   = ale_pkg::cmd_t'(command);
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign pos_ok   = pos_w < cnt_w;
	assign cnt_zero = (count_q == '0);
	assign cnt_full = (count_q == CW'(CAPACITY));
	assign last_idx = AW'(count_q - 1'b1);
	assign pos_idx  = AW'(position);

	always_comb begin
		tgt_d = '0;
		bad_d = 1'b0;
		ptr_d = '0;
		case (cmd_in)
			ale_pkg::CMD_INSERT: begin
				tgt_d = use_last ? AW'(count_q) : pos_idx;
				bad_d = !use_last && !pos_ok;
				ptr_d = last_idx;
			end
			ale_pkg::CMD_REMOVE: begin
				tgt_d = use_last ? last_idx : pos_idx;
				bad_d = use_last ? cnt_zero : !pos_ok;
				ptr_d = AW'(tgt_d + 1'b1);
			end
			ale_pkg::CMD_GET: begin
				tgt_d = use_last ? last_idx : pos_idx;
				bad_d = use_last ? cnt_zero : !pos_ok;
				ptr_d = tgt_d;
			end
			default: begin
				tgt_d = '0;
				bad_d = 1'b0;
				ptr_d = '0;
			end
		endcase
	end

	// item fields and walk pointer
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q    <= cmd_in;
			tgt_q    <= tgt_d;
			bad_q    <= bad_d;
			val_q    <= ELEM_WIDTH'(value);
			rd_ptr_q <= ptr_d;
		end else if (ctrl.rd) begin
			if (cmd_q == ale_pkg::CMD_INSERT) begin
				rd_ptr_q <= AW'(rd_ptr_q - 1'b1);
			end else begin
				rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			rdv_s1 <= ctrl.rd;
			if (ctrl.cnt_inc) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (ctrl.cnt_dec) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	// store: one write port, one registered read port
	assign wr_en   = ctrl.wr_val | ctrl.wr_shift;
	assign wr_data = ctrl.wr_val ? val_q : rdata_s1;

	always_comb begin
		if (ctrl.wr_val) begin
			wr_addr = tgt_q;
		end else if (cmd_q == ale_pkg::CMD_INSERT) begin
			wr_addr = AW'(rdaddr_s1 + 1'b1);
		end else begin
			wr_addr = AW'(rdaddr_s1 - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rdata_s1  <= store_q[rd_ptr_q];
			rdaddr_s1 <= rd_ptr_q;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			status_q      <= ctrl.status;
			count_res_q   <= 9'(count_q);
			found_q       <= ctrl.hit;
			found_index_q <= ctrl.hit ? 8'(rdaddr_s1) : 8'd0;
			read_value_q  <= (cmd_q == ale_pkg::CMD_GET && ctrl.status == ale_pkg::ST_OK)
				? 32'(rdata_s1) : 32'd0;
			is_full_q     <= cnt_full;
			is_empty_q    <= cnt_zero;
		end
	end

	// insert: tail means the target is the count (append); otherwise the last entry
	assign stat.cmd     = cmd_q;
	assign stat.bad     = bad_q;
	assign stat.full    = cnt_full;
	assign stat.empty   = cnt_zero;
	assign stat.tail    = (cmd_q == ale_pkg::CMD_INSERT) ? (tgt_q == AW'(count_q))
		: (tgt_q == last_idx);
	assign stat.rd_last = (cmd_q == ale_pkg::CMD_INSERT) ? (rd_ptr_q == tgt_q)
		: (rd_ptr_q == last_idx);
	assign stat.rdv     = rdv_s1;
	assign stat.match   = (rdata_s1 == val_q);

	assign status      = status_q;
	assign count       = count_res_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign read_value  = read_value_q;
	assign is_full     = is_full_q;
	assign is_empty    = is_empty_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cnt_inc |-> !cnt_full)
		else $error("count increment on a full list");

	a_dec_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cnt_dec |-> !cnt_zero)
		else $error("count decrement on an empty list");

	a_shift_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_shift |-> rdv_s1)
		else $error("shift write without read data");

endmodule

`default_nettype wire

// File: rtl/ale_ctrl.sv
// Controller of the array list engine: sequences decode, shift walks,
// search scan and result reporting.
// Depends on ale_pkg.
`default_nettype none

module ale_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output logic                done,
	input  wire ale_pkg::stat_t stat,
	output ale_pkg::ctrl_t      ctrl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_UP,
		S_UP_DRAIN,
		S_UP_PUT,
		S_SHIFT_DN,
		S_DN_DRAIN,
		S_SCAN,
		S_SCAN_TAIL,
		S_REPORT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		ctrl        = '0;
		ctrl.status = ale_pkg::ST_OK;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				ctrl.latch = start;
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					ale_pkg::CMD_INSERT: begin
						if (stat.full) begin
							ctrl.finish = 1'b1;
							ctrl.status = ale_pkg::ST_FULL;
							state_d     = S_IDLE;
						end else if (stat.bad) begin
							ctrl.finish = 1'b1;
							ctrl.status = ale_pkg::ST_BAD_POS;
							state_d     = S_IDLE;
						end else if (stat.tail || stat.empty) begin
							// append: target is the count itself
							ctrl.wr_val  = 1'b1;
							ctrl.cnt_inc = 1'b1;
							state_d      = S_REPORT;
						end else begin
							ctrl.rd = 1'b1;
							state_d = stat.rd_last ? S_UP_DRAIN : S_SHIFT_UP;
						end
					end
					ale_pkg::CMD_REMOVE: begin
						if (stat.bad) begin
							ctrl.finish = 1'b1;
							ctrl.status = ale_pkg::ST_BAD_POS;
							state_d     = S_IDLE;
						end else if (stat.tail) begin
							ctrl.cnt_dec = 1'b1;
							state_d      = S_REPORT;
						end else begin
							ctrl.rd = 1'b1;
							state_d = stat.rd_last ? S_DN_DRAIN : S_SHIFT_DN;
						end
					end
					ale_pkg::CMD_GET: begin
						if (stat.bad) begin
							ctrl.finish = 1'b1;
							ctrl.status = ale_pkg::ST_BAD_POS;
							state_d     = S_IDLE;
						end else begin
							ctrl.rd = 1'b1;
							state_d = S_REPORT;
						end
					end
					default: begin
						if (stat.empty) begin
							ctrl.finish = 1'b1;
							state_d     = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
				endcase
			end
			S_SHIFT_UP: begin
				ctrl.rd       = 1'b1;
				ctrl.wr_shift = 1'b1;
				if (stat.rd_last) begin
					state_d = S_UP_DRAIN;
				end
			end
			S_UP_DRAIN: begin
				ctrl.wr_shift = 1'b1;
				state_d       = S_UP_PUT;
			end
			S_UP_PUT: begin
				ctrl.wr_val  = 1'b1;
				ctrl.cnt_inc = 1'b1;
				state_d      = S_REPORT;
			end
			S_SHIFT_DN: begin
				ctrl.rd       = 1'b1;
				ctrl.wr_shift = 1'b1;
				if (stat.rd_last) begin
					state_d = S_DN_DRAIN;
				end
			end
			S_DN_DRAIN: begin
				ctrl.wr_shift = 1'b1;
				ctrl.cnt_dec  = 1'b1;
				state_d       = S_REPORT;
			end
			S_SCAN: begin
				if (stat.rdv && stat.match) begin
					ctrl.hit    = 1'b1;
					ctrl.finish = 1'b1;
					state_d     = S_IDLE;
				end else begin
					ctrl.rd = 1'b1;
					if (stat.rd_last) begin
						state_d = S_SCAN_TAIL;
					end
				end
			end
			S_SCAN_TAIL: begin
				ctrl.hit    = stat.rdv && stat.match;
				ctrl.finish = 1'b1;
				state_d     = S_IDLE;
			end
			S_REPORT: begin
				ctrl.finish = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctrl.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> (done_q && !busy))
		else $error("finish not followed by strobe and idle");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr_val && ctrl.wr_shift))
		else $error("two store writes in one cycle");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for array_list_engine: insert, remove, get and search
// words, checked against a behavioral list model kept in the bench.
// Depends on ale_pkg and array_list_engine.
module tb;

	localparam int LIST_DEPTH     = 256;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DIRECTED_ROWS  = 25;

	typedef struct packed {
		ale_pkg::status_t status;
		logic [8:0]       count;
		logic             found;
		logic [7:0]       found_index;
		logic [31:0]      read_value;
		logic             is_full;
		logic             is_empty;
	} list_result_t;

	typedef struct packed {
		ale_pkg::cmd_t cmd;
		logic          use_last;
		logic [7:0]    position;
		logic [31:0]   value;
		logic          typed;
		list_result_t  want;
	} list_cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic        use_last;
	logic [7:0]  position;
	logic [31:0] value;
	logic        done;
	logic [1:0]  status;
	logic [8:0]  count;
	logic        found;
	logic [7:0]  found_index;
	logic [31:0] read_value;
	logic        is_full;
	logic        is_empty;

	array_list_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.use_last    (use_last),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.count       (count),
		.found       (found),
		.found_index (found_index),
		.read_value  (read_value),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

	always #1 clk = ~clk;

	// bench copy of the list
	logic [31:0]   list_mem [LIST_DEPTH];
	int            list_len;
	bit            growing;
	int            idle_pct;

	list_result_t  pending_results [$];
	list_result_t  oldest;
	list_cmd_row_t directed_rows [DIRECTED_ROWS];

	int mismatches;
	int idle_cycles;
	int per_cmd [4];
	int bad_pos_rejects;
	int full_rejects;
	int search_hits;
	int peak_len;

	function automatic list_result_t predict_list_op(ale_pkg::cmd_t c, bit ul,
			logic [7:0] pos, logic [31:0] v);
		list_result_t r;
		int slot;
		int k;
		bit hit;
		r = '0;
		r.status = ale_pkg::ST_OK;
		slot = ul ? list_len - 1 : int'(pos);
		case (c)
			ale_pkg::CMD_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = ale_pkg::ST_FULL;
				end else if (ul) begin
					list_mem[8'(list_len)] = v;
					list_len++;
				end else if (int'(pos) < list_len) begin
					for (k = list_len; k > int'(pos); k--)
						list_mem[8'(k)] = list_mem[8'(k - 1)];
					list_mem[pos] = v;
					list_len++;
				end else begin
					r.status = ale_pkg::ST_BAD_POS;
				end
			end
			ale_pkg::CMD_REMOVE: begin
				if (slot < 0 || slot >= list_len) begin
					r.status = ale_pkg::ST_BAD_POS;
				end else begin
					for (k = slot; k + 1 < list_len; k++)
						list_mem[8'(k)] = list_mem[8'(k + 1)];
					list_len--;
				end
			end
			ale_pkg::CMD_GET: begin
				if (slot < 0 || slot >= list_len)
					r.status = ale_pkg::ST_BAD_POS;
				else
					r.read_value = list_mem[8'(slot)];
			end
			default: begin
				hit = 1'b0;
				k = 0;
				while (!hit && k < list_len) begin
					if (list_mem[8'(k)] == v) begin
						hit = 1'b1;
						r.found = 1'b1;
						r.found_index = k[7:0];
					end
					k++;
				end
			end
		endcase
		r.count = list_len[8:0];
		r.is_full = (list_len == LIST_DEPTH);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	function automatic list_result_t outcome(ale_pkg::status_t st, int cnt, bit fnd, int idx,
			logic [31:0] rv);
		list_result_t r;
		r.status = st;
		r.count = cnt[8:0];
		r.found = fnd;
		r.found_index = idx[7:0];
		r.read_value = rv;
		r.is_full = (cnt == LIST_DEPTH);
		r.is_empty = (cnt == 0);
		return r;
	endfunction

	function automatic list_cmd_row_t mk_row(ale_pkg::cmd_t c, bit ul, logic [7:0] pos,
			logic [31:0] v, bit typed, list_result_t want);
		list_cmd_row_t row;
		row.cmd = c;
		row.use_last = ul;
		row.position = pos;
		row.value = v;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom();
			1: v = (list_len > 0) ? list_mem[8'($urandom_range(list_len - 1))] : $urandom();
			2: begin
				case ($urandom_range(3))
					0: v = 32'h0000_0000;
					1: v = 32'hFFFF_FFFF;
					2: v = 32'h8000_0001;
					default: v = 32'h7FFF_FFFE;
				endcase
			end
			default: v = $urandom_range(15);
		endcase
		return v;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// one command word: optional sender idle, hold until taken, then predict
	task automatic issue(ale_pkg::cmd_t c, bit ul, logic [7:0] pos, logic [31:0] v, bit typed,
			list_result_t want);
		list_result_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		command <= c;
		use_last <= ul;
		position <= pos;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = predict_list_op(c, ul, pos, v);
		per_cmd[c]++;
		if (predicted.status == ale_pkg::ST_BAD_POS) bad_pos_rejects++;
		if (predicted.status == ale_pkg::ST_FULL) full_rejects++;
		if (predicted.found) search_hits++;
		if (list_len > peak_len) peak_len = list_len;
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic random_item();
		ale_pkg::cmd_t c;
		bit ul;
		logic [7:0] pos;
		int roll;
		if (list_len == LIST_DEPTH) growing = 1'b0;
		else if (list_len == 0) growing = 1'b1;
		else if ($urandom_range(99) < 1) growing = !growing;
		roll = $urandom_range(99);
		if (roll < 10) begin
			c = ale_pkg::cmd_t'($urandom_range(3));
			ul = 1'($urandom_range(1));
			pos = 8'($urandom_range(255));
		end else begin
			roll = $urandom_range(99);
			if (roll < 55) c = growing ? ale_pkg::CMD_INSERT : ale_pkg::CMD_REMOVE;
			else if (roll < 65) c = growing ? ale_pkg::CMD_REMOVE : ale_pkg::CMD_INSERT;
			else if (roll < 82) c = ale_pkg::CMD_GET;
			else c = ale_pkg::CMD_SEARCH;
			ul = ($urandom_range(99) < 30);
			pos = (list_len > 0) ? 8'($urandom_range(list_len - 1)) : 8'd0;
		end
		issue(c, ul, pos, pick_value(), 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result word, status %0d count %0d",
						$time, status, count);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					compare_field("status", oldest.status, status);
					compare_field("count", oldest.count, count);
					compare_field("found", oldest.found, found);
					compare_field("found_index", oldest.found_index, found_index);
					compare_field("read_value", oldest.read_value, read_value);
					compare_field("is_full", oldest.is_full, is_full);
					compare_field("is_empty", oldest.is_empty, is_empty);
				end
			end
			if (done || (start && !busy)) begin
				idle_cycles = 0;
			end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending_results.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= ale_pkg::CMD_INSERT;
		use_last <= 1'b0;
		position <= 8'd0;
		value <= 32'd0;
		list_len = 0;
		growing = 1'b1;
		mismatches = 0;
		idle_cycles = 0;
		bad_pos_rejects = 0;
		full_rejects = 0;
		search_hits = 0;
		peak_len = 0;
		per_cmd = '{0, 0, 0, 0};

		directed_rows[0]  = mk_row(ale_pkg::CMD_GET, 1, 8'd0, 32'd0, 1,
			outcome(ale_pkg::ST_BAD_POS, 0, 0, 0, 0));
		directed_rows[1]  = mk_row(ale_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 1,
			outcome(ale_pkg::ST_BAD_POS, 0, 0, 0, 0));
		directed_rows[2]  = mk_row(ale_pkg::CMD_REMOVE, 0, 8'd0, 32'd0, 1,
			outcome(ale_pkg::ST_BAD_POS, 0, 0, 0, 0));
		directed_rows[3]  = mk_row(ale_pkg::CMD_GET, 0, 8'hFF, 32'd0, 1,
			outcome(ale_pkg::ST_BAD_POS, 0, 0, 0, 0));
		directed_rows[4]  = mk_row(ale_pkg::CMD_INSERT, 0, 8'd0, 32'h1111_1111, 1,
			outcome(ale_pkg::ST_BAD_POS, 0, 0, 0, 0));
		directed_rows[5]  = mk_row(ale_pkg::CMD_SEARCH, 0, 8'd0, 32'd0, 1,
			outcome(ale_pkg::ST_OK, 0, 0, 0, 0));
		directed_rows[6]  = mk_row(ale_pkg::CMD_INSERT, 1, 8'd0, 32'hFFFF_FFFF, 1,
			outcome(ale_pkg::ST_OK, 1, 0, 0, 0));
		directed_rows[7]  = mk_row(ale_pkg::CMD_INSERT, 1, 8'hFF, 32'd0, 1,
			outcome(ale_pkg::ST_OK, 2, 0, 0, 0));
		directed_rows[8]  = mk_row(ale_pkg::CMD_INSERT, 0, 8'd0, 32'hA5A5_5A5A, 1,
			outcome(ale_pkg::ST_OK, 3, 0, 0, 0));
		directed_rows[9]  = mk_row(ale_pkg::CMD_GET, 0, 8'd0, 32'd0, 1,
			outcome(ale_pkg::ST_OK, 3, 0, 0, 32'hA5A5_5A5A));
		directed_rows[10] = mk_row(ale_pkg::CMD_GET, 0, 8'd1, 32'd0, 1,
			outcome(ale_pkg::ST_OK, 3, 0, 0, 32'hFFFF_FFFF));
		directed_rows[11] = mk_row(ale_pkg::CMD_GET, 1, 8'hFF, 32'hFFFF_FFFF, 1,
			outcome(ale_pkg::ST_OK, 3, 0, 0, 32'd0));
		directed_rows[12] = mk_row(ale_pkg::CMD_GET, 0, 8'hFF, 32'd0, 1,
			outcome(ale_pkg::ST_BAD_POS, 3, 0, 0, 0));
		directed_rows[13] = mk_row(ale_pkg::CMD_INSERT, 0, 8'hFF, 32'hFFFF_FFFF, 1,
			outcome(ale_pkg::ST_BAD_POS, 3, 0, 0, 0));
		directed_rows[14] = mk_row(ale_pkg::CMD_INSERT, 0, 8'd3, 32'h0000_0003, 1,
			outcome(ale_pkg::ST_BAD_POS, 3, 0, 0, 0));
		directed_rows[15] = mk_row(ale_pkg::CMD_SEARCH, 0, 8'd0, 32'hFFFF_FFFF, 1,
			outcome(ale_pkg::ST_OK, 3, 1, 1, 0));
		directed_rows[16] = mk_row(ale_pkg::CMD_SEARCH, 1, 8'hFF, 32'd0, 1,
			outcome(ale_pkg::ST_OK, 3, 1, 2, 0));
		directed_rows[17] = mk_row(ale_pkg::CMD_SEARCH, 0, 8'd0, 32'h1234_5678, 1,
			outcome(ale_pkg::ST_OK, 3, 0, 0, 0));
		directed_rows[18] = mk_row(ale_pkg::CMD_INSERT, 0, 8'd2, 32'h0000_0001, 0, '0);
		directed_rows[19] = mk_row(ale_pkg::CMD_REMOVE, 0, 8'd1, 32'd0, 0, '0);
		directed_rows[20] = mk_row(ale_pkg::CMD_SEARCH, 0, 8'd0, 32'hFFFF_FFFF, 0, '0);
		directed_rows[21] = mk_row(ale_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 0, '0);
		directed_rows[22] = mk_row(ale_pkg::CMD_GET, 0, 8'd1, 32'd0, 0, '0);
		directed_rows[23] = mk_row(ale_pkg::CMD_REMOVE, 0, 8'd0, 32'd0, 0, '0);
		directed_rows[24] = mk_row(ale_pkg::CMD_SEARCH, 0, 8'd0, 32'h0000_0001, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 10;
		foreach (directed_rows[i])
			issue(directed_rows[i].cmd, directed_rows[i].use_last, directed_rows[i].position,
				directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);

		// fill to capacity, then the full-list cases
		while (list_len < LIST_DEPTH)
			issue(ale_pkg::CMD_INSERT, 1'($urandom_range(1)),
				(list_len > 0) ? 8'($urandom_range(list_len - 1)) : 8'd0, $urandom(),
				1'b0, '0);
		issue(ale_pkg::CMD_INSERT, 1, 8'd0, 32'hFFFF_FFFF, 1,
			outcome(ale_pkg::ST_FULL, LIST_DEPTH, 0, 0, 0));
		issue(ale_pkg::CMD_INSERT, 0, 8'd0, 32'd0, 1,
			outcome(ale_pkg::ST_FULL, LIST_DEPTH, 0, 0, 0));
		issue(ale_pkg::CMD_INSERT, 0, 8'hFF, 32'd0, 1,
			outcome(ale_pkg::ST_FULL, LIST_DEPTH, 0, 0, 0));
		issue(ale_pkg::CMD_SEARCH, 0, 8'd0, list_mem[8'(LIST_DEPTH - 1)], 1'b0, '0);
		issue(ale_pkg::CMD_SEARCH, 0, 8'd0, $urandom(), 1'b0, '0);
		issue(ale_pkg::CMD_GET, 0, 8'hFF, 32'd0, 1'b0, '0);
		issue(ale_pkg::CMD_REMOVE, 0, 8'd0, 32'd0, 1'b0, '0);
		issue(ale_pkg::CMD_INSERT, 0, 8'd254, 32'h5A5A_A5A5, 1'b0, '0);
		issue(ale_pkg::CMD_REMOVE, 1, 8'd0, 32'd0, 1'b0, '0);

		repeat (150) random_item();
		idle_pct = 68;
		repeat (250) random_item();
		idle_pct = 0;
		repeat (250) random_item();

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d insert, %0d remove, %0d get and %0d search words, peak length %0d.",
			per_cmd[ale_pkg::CMD_INSERT], per_cmd[ale_pkg::CMD_REMOVE],
			per_cmd[ale_pkg::CMD_GET], per_cmd[ale_pkg::CMD_SEARCH], peak_len);
		$display("Saw %0d bad-position and %0d list-full rejections, %0d search hits.",
			bad_pos_rejects, full_rejects, search_hits);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: array_list_engine.f
rtl/ale_pkg.sv
rtl/ale_dpath.sv
rtl/ale_ctrl.sv
rtl/array_list_engine.sv
bench/tb.sv
